@@ design/pbnp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pbnp_pkg;

    // Default bin count
    localparam int BINS_DEF = 512;

    // Action codes
    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_ADD   = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_ANGLE_MIN = 2'd0;
    localparam logic [1:0] CFG_ANGLE_MAX = 2'd1;
    localparam logic [1:0] CFG_ANGLE_STEP = 2'd2;
    localparam logic [1:0] CFG_RANGE_MIN = 2'd3;

    // Reset values of the configuration registers
    localparam logic signed [15:0] ANGLE_MIN_RST  = -16'sd25735;
    localparam logic signed [15:0] ANGLE_MAX_RST  = 16'sd25735;
    localparam logic [13:0]        ANGLE_STEP_RST = 14'd115;
    localparam logic [14:0]        RANGE_MIN_RST  = 15'd250;

    // Datapath widths and constants
    localparam int CW = 36;
    localparam int ZW = 20;
    localparam logic [4:0] ITER_LAST = 5'd17;
    localparam logic [4:0] DIV_LAST  = 5'd15;
    localparam logic signed [ZW-1:0] Z_HALF_PI = 20'sd102944;
    localparam logic signed [ZW-1:0] ANG_LIM   = 20'sd25736;

    // Bin entry as stored in memory
    typedef struct packed {
        logic        filled;
        logic [15:0] range_mm;
        logic [15:0] level;
    } pbnp_entry_t;

    localparam int ENTRY_W = $bits(pbnp_entry_t);

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic sq;
        logic iter_init;
        logic iter_step;
        logic ang;
        logic div_step;
        logic look;
        logic upd;
        logic clr_step;
        logic out_load;
    } pbnp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic chk_pass;
        logic iter_last;
        logic ang_pass;
        logic div_last;
        logic idx_pass;
        logic clr_last;
    } pbnp_sts_t;

    // CORDIC arctangent table, 2^-16 rad units
    function automatic logic signed [ZW-1:0] atan_lut(input logic [3:0] i);
        logic signed [ZW-1:0] v;
        case (i)
            4'd0:    v = 20'sd51472;
            4'd1:    v = 20'sd30385;
            4'd2:    v = 20'sd16055;
            4'd3:    v = 20'sd8150;
            4'd4:    v = 20'sd4091;
            4'd5:    v = 20'sd2047;
            4'd6:    v = 20'sd1024;
            4'd7:    v = 20'sd512;
            4'd8:    v = 20'sd256;
            4'd9:    v = 20'sd128;
            4'd10:   v = 20'sd64;
            4'd11:   v = 20'sd32;
            4'd12:   v = 20'sd16;
            4'd13:   v = 20'sd8;
            4'd14:   v = 20'sd4;
            4'd15:   v = 20'sd2;
            default: v = 20'sd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ design/pbnp_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pbnp_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 512
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ design/pbnp_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pbnp_dp #(
    parameter int BINS = 512
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_we,
    input  wire logic [1:0]          cfg_addr,
    input  wire logic [15:0]         cfg_wdata,
    input  wire logic signed [15:0]  s_x_mm,
    input  wire logic signed [15:0]  s_y_mm,
    input  wire logic [15:0]         s_point_intensity,
    input  wire logic                s_point_ok,
    input  wire logic [8:0]          s_read_bin,
    input  wire pbnp_pkg::pbnp_cmd_t cmd,
    output pbnp_pkg::pbnp_sts_t      sts,
    output logic [15:0]              m_range_mm,
    output logic [15:0]              m_bin_intensity,
    output logic                     m_bin_filled
);
    import pbnp_pkg::*;

    localparam int AW = $clog2(BINS);

    // Configuration registers
    logic signed [15:0] amin_reg;
    logic signed [15:0] amax_reg;
    logic [13:0]        step_reg;
    logic [14:0]        rmin_reg;

    // Latched item
    logic signed [15:0] x_reg;
    logic signed [15:0] y_reg;
    logic [15:0]        lvl_reg;
    logic               ok_reg;
    logic               rd_in_reg;
    logic [AW-1:0]      addr_reg;
    logic [AW-1:0]      clr_addr_reg;

    // Squares
    logic [31:0] xx_reg;
    logic [31:0] yy_reg;
    logic [29:0] rmin2_reg;
    logic [32:0] rsq;

    // CORDIC and square root
    logic signed [CW-1:0] cx_reg, cx_next;
    logic signed [CW-1:0] cy_reg, cy_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic                 zp_reg;
    logic [CW-1:0]        sqv_reg, sqv_next;
    logic [CW-1:0]        sqr_reg, sqr_next;
    logic [4:0]           cnt_reg;
    logic signed [CW-1:0] cx0, cy0, sx, sy;
    logic [CW-1:0]        sbit, ssum;

    // Angle, divider, radius
    logic signed [ZW-1:0] zr;
    logic signed [15:0]   ang;
    logic signed [16:0]   diff;
    logic [15:0]          q_reg;
    logic [13:0]          rem_reg;
    logic [14:0]          dtrial;
    logic [15:0]          rad_reg;
    logic [CW-1:0]        rad_full;

    // Memory
    pbnp_entry_t ram_rd;
    pbnp_entry_t ram_wd;
    logic        ram_we;
    logic [AW-1:0] ram_waddr;
    logic [ENTRY_W-1:0] ram_rdata;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            amin_reg <= ANGLE_MIN_RST;
            amax_reg <= ANGLE_MAX_RST;
            step_reg <= ANGLE_STEP_RST;
            rmin_reg <= RANGE_MIN_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_ANGLE_MIN:  amin_reg <= cfg_wdata;
                CFG_ANGLE_MAX:  amax_reg <= cfg_wdata;
                CFG_ANGLE_STEP: step_reg <= cfg_wdata[13:0];
                CFG_RANGE_MIN:  rmin_reg <= cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    // Range gate
    assign rsq = {1'b0, xx_reg} + {1'b0, yy_reg};
    assign sts.chk_pass = ok_reg && (rsq >= {3'b0, rmin2_reg});

    // Pre-rotation for the left half plane
    always_comb begin
        cx0 = {{(CW-32){x_reg[15]}}, x_reg, 16'b0};
        cy0 = {{(CW-32){y_reg[15]}}, y_reg, 16'b0};
    end

    // One CORDIC micro-rotation and one root digit
    always_comb begin
        sx = cx_reg >>> cnt_reg[3:0];
        sy = cy_reg >>> cnt_reg[3:0];
        cx_next = cx_reg;
        cy_next = cy_reg;
        z_next  = z_reg;
        if (!cnt_reg[4]) begin
            if (cy_reg > 0) begin
                cx_next = cx_reg + sy;
                cy_next = cy_reg - sx;
                z_next  = z_reg + atan_lut(cnt_reg[3:0]);
            end else begin
                cx_next = cx_reg - sy;
                cy_next = cy_reg + sx;
                z_next  = z_reg - atan_lut(cnt_reg[3:0]);
            end
        end
        sbit = CW'(1) << (6'd34 - {cnt_reg, 1'b0});
        ssum = sqr_reg + sbit;
        if (sqv_reg >= ssum) begin
            sqv_next = sqv_reg - ssum;
            sqr_next = (sqr_reg >> 1) + sbit;
        end else begin
            sqv_next = sqv_reg;
            sqr_next = sqr_reg >> 1;
        end
    end

    assign sts.iter_last = (cnt_reg == ITER_LAST);
    assign sts.div_last  = (cnt_reg == DIV_LAST);

    // Round and clamp the angle to Q2.13, then window it
    always_comb begin
        zr = (z_reg + ZW'(4)) >>> 3;
        if (zp_reg) begin
            ang = 16'sd0;
        end else if (zr > ANG_LIM) begin
            ang = ANG_LIM[15:0];
        end else if (zr < -ANG_LIM) begin
            ang = 16'(-ANG_LIM);
        end else begin
            ang = zr[15:0];
        end
        diff = {ang[15], ang} - {amin_reg[15], amin_reg};
    end

    assign sts.ang_pass = (ang >= amin_reg) && (ang <= amax_reg) && (step_reg != 14'd0);

    // Restoring divider trial
    assign dtrial = {rem_reg, q_reg[15]};
    assign sts.idx_pass = (32'(q_reg) < BINS);

    assign rad_full = (sqr_reg + CW'(1)) >> 1;

    assign sts.clr_last = (32'(clr_addr_reg) == BINS - 1);

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
            cnt_reg      <= '0;
        end else begin
            if (cmd.load) begin
                clr_addr_reg <= '0;
            end else if (cmd.clr_step) begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            // Hold the count on the last root step
            if (cmd.iter_init || cmd.ang) begin
                cnt_reg <= '0;
            end else if ((cmd.iter_step && !sts.iter_last) || cmd.div_step) begin
                cnt_reg <= cnt_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        // Latch the item
        if (cmd.load) begin
            x_reg     <= s_x_mm;
            y_reg     <= s_y_mm;
            lvl_reg   <= s_point_intensity;
            ok_reg    <= s_point_ok;
            rd_in_reg <= (32'(s_read_bin) < BINS);
            addr_reg  <= AW'(s_read_bin);
        end
        // Squares
        if (cmd.sq) begin
            xx_reg    <= 32'(x_reg * x_reg);
            yy_reg    <= 32'(y_reg * y_reg);
            rmin2_reg <= rmin_reg * rmin_reg;
        end
        // Start CORDIC and root
        if (cmd.iter_init) begin
            zp_reg  <= (x_reg == 16'sd0) && (y_reg == 16'sd0);
            sqv_reg <= CW'({rsq, 2'b00});
            sqr_reg <= '0;
            if (x_reg[15]) begin
                if (!y_reg[15]) begin
                    cx_reg <= cy0;
                    cy_reg <= -cx0;
                    z_reg  <= Z_HALF_PI;
                end else begin
                    cx_reg <= -cy0;
                    cy_reg <= cx0;
                    z_reg  <= -Z_HALF_PI;
                end
            end else begin
                cx_reg <= cx0;
                cy_reg <= cy0;
                z_reg  <= '0;
            end
        end else if (cmd.iter_step) begin
            cx_reg  <= cx_next;
            cy_reg  <= cy_next;
            z_reg   <= z_next;
            sqv_reg <= sqv_next;
            sqr_reg <= sqr_next;
        end
        // Start divider, round radius
        if (cmd.ang) begin
            q_reg   <= diff[15:0];
            rem_reg <= '0;
            rad_reg <= rad_full[15:0];
        end else if (cmd.div_step) begin
            if (dtrial >= {1'b0, step_reg}) begin
                rem_reg <= 14'(dtrial - {1'b0, step_reg});
                q_reg   <= {q_reg[14:0], 1'b1};
            end else begin
                rem_reg <= dtrial[13:0];
                q_reg   <= {q_reg[14:0], 1'b0};
            end
        end
        // Point the memory at the bin
        if (cmd.look) begin
            addr_reg <= q_reg[AW-1:0];
        end
        // Result register
        if (cmd.out_load) begin
            if (rd_in_reg && ram_rd.filled) begin
                m_range_mm      <= ram_rd.range_mm;
                m_bin_intensity <= ram_rd.level;
                m_bin_filled    <= 1'b1;
            end else begin
                m_range_mm      <= '0;
                m_bin_intensity <= '0;
                m_bin_filled    <= 1'b0;
            end
        end
    end

    // Memory write: sweep or nearest-point update
    assign ram_rd = pbnp_entry_t'(ram_rdata);
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wd    = '0;
        if (cmd.clr_step) begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
        end else if (cmd.upd && (!ram_rd.filled || rad_reg < ram_rd.range_mm)) begin
            ram_we          = 1'b1;
            ram_wd.filled   = 1'b1;
            ram_wd.range_mm = rad_reg;
            ram_wd.level    = lvl_reg;
        end
    end

    pbnp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (BINS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wd),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    // Iteration count stays within the root loop
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= ITER_LAST)
        else $error("iteration count out of range");

    // The sweep never overlaps an update
    a_wr_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.clr_step && cmd.upd))
        else $error("sweep and update together");

endmodule

`default_nettype wire

@@ design/pbnp_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pbnp_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [1:0]          s_action,
    output logic                     m_valid,
    input  wire logic                m_ready,
    input  wire pbnp_pkg::pbnp_sts_t sts,
    output pbnp_pkg::pbnp_cmd_t      cmd
);
    import pbnp_pkg::*;

    localparam logic [3:0] ST_CLR   = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_SQ    = 4'd2;
    localparam logic [3:0] ST_CHK   = 4'd3;
    localparam logic [3:0] ST_ITER  = 4'd4;
    localparam logic [3:0] ST_ANG   = 4'd5;
    localparam logic [3:0] ST_DIV   = 4'd6;
    localparam logic [3:0] ST_IDX   = 4'd7;
    localparam logic [3:0] ST_LOOK  = 4'd8;
    localparam logic [3:0] ST_UPD   = 4'd9;
    localparam logic [3:0] ST_RLOOK = 4'd10;
    localparam logic [3:0] ST_OUT   = 4'd11;

    logic [3:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       acc;

    assign s_ready = (state_reg == ST_IDLE);
    assign acc     = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    // Sequence one item
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (acc) begin
                    cmd.load = 1'b1;
                    case (s_action)
                        ACT_CLEAR: state_next = ST_CLR;
                        ACT_ADD:   state_next = ST_SQ;
                        ACT_READ:  state_next = ST_RLOOK;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SQ: begin
                cmd.sq     = 1'b1;
                state_next = ST_CHK;
            end
            ST_CHK: begin
                if (sts.chk_pass) begin
                    cmd.iter_init = 1'b1;
                    state_next    = ST_ITER;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_ITER: begin
                cmd.iter_step = 1'b1;
                if (sts.iter_last) begin
                    state_next = ST_ANG;
                end
            end
            ST_ANG: begin
                if (sts.ang_pass) begin
                    cmd.ang    = 1'b1;
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_IDX;
                end
            end
            ST_IDX: begin
                if (sts.idx_pass) begin
                    cmd.look   = 1'b1;
                    state_next = ST_LOOK;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_LOOK: state_next = ST_UPD;
            ST_UPD: begin
                cmd.upd    = 1'b1;
                state_next = ST_IDLE;
            end
            ST_RLOOK: state_next = ST_OUT;
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Output beat flag
    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Never overwrite a waiting beat
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result overwritten");

    // A beat appears only from the output state
    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_OUT)
        else $error("result raised outside output state");

    // An add starts with the squares
    a_add_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && s_action == ACT_ADD) |=> state_reg == ST_SQ)
        else $error("add did not start");

endmodule

`default_nettype wire

@@ design/polar_bin_nearest_point_top.sv @@
// Channel  | Handshake          | Beat contents
// ---------+--------------------+------------------------------------------------
// input    | s_valid / s_ready  | action, x_mm, y_mm, point_intensity, ok, read_bin
// result   | m_valid / m_ready  | range_mm, bin_intensity, bin_filled (reads only)
// config   | cfg_we             | cfg_addr selects register, cfg_wdata value
//
// An add runs: square, range gate, 18 root steps (the first 16 also CORDIC steps),
// angle gate, 16 divider steps, bin check, one memory read and at most one write.
// A read looks up the bin, then loads the result register once any earlier result is taken;
// the result register frees the input. A clear, and the pass after reset, sweep the bin
// memory one entry a cycle, during which no item is accepted.
`timescale 1ns / 1ps
`default_nettype none

module polar_bin_nearest_point_top #(
    parameter int BINS = pbnp_pkg::BINS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_addr,
    input  wire logic [15:0]        cfg_wdata,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_action,
    input  wire logic signed [15:0] s_x_mm,
    input  wire logic signed [15:0] s_y_mm,
    input  wire logic [15:0]        s_point_intensity,
    input  wire logic               s_point_ok,
    input  wire logic [8:0]         s_read_bin,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [15:0]             m_range_mm,
    output logic [15:0]             m_bin_intensity,
    output logic                    m_bin_filled
);
    import pbnp_pkg::*;

    pbnp_cmd_t cmd;
    pbnp_sts_t sts;

    pbnp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_action),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pbnp_dp #(
        .BINS (BINS)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_addr          (cfg_addr),
        .cfg_wdata         (cfg_wdata),
        .s_x_mm            (s_x_mm),
        .s_y_mm            (s_y_mm),
        .s_point_intensity (s_point_intensity),
        .s_point_ok        (s_point_ok),
        .s_read_bin        (s_read_bin),
        .cmd               (cmd),
        .sts               (sts),
        .m_range_mm        (m_range_mm),
        .m_bin_intensity   (m_bin_intensity),
        .m_bin_filled      (m_bin_filled)
    );

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import pbnp_pkg::*;

    localparam int         NBINS    = 512;
    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam int         SETTLE   = NBINS + 100;

    typedef struct packed {
        logic [15:0] range_mm;
        logic [15:0] level;
        logic        filled;
    } bin_read_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_we;
    logic [1:0]         cfg_addr;
    logic [15:0]        cfg_wdata;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_action;
    logic signed [15:0] s_x_mm;
    logic signed [15:0] s_y_mm;
    logic [15:0]        s_point_intensity;
    logic               s_point_ok;
    logic [8:0]         s_read_bin;
    logic               m_valid;
    logic               m_ready;
    logic [15:0]        m_range_mm;
    logic [15:0]        m_bin_intensity;
    logic               m_bin_filled;

    polar_bin_nearest_point_top i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_addr          (cfg_addr),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_action          (s_action),
        .s_x_mm            (s_x_mm),
        .s_y_mm            (s_y_mm),
        .s_point_intensity (s_point_intensity),
        .s_point_ok        (s_point_ok),
        .s_read_bin        (s_read_bin),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_range_mm        (m_range_mm),
        .m_bin_intensity   (m_bin_intensity),
        .m_bin_filled      (m_bin_filled)
    );

    // Shadow of the block: window registers and bin contents
    logic signed [15:0] win_min;
    logic signed [15:0] win_max;
    logic [13:0]        win_step;
    logic [14:0]        near_limit;
    logic               shadow_valid [NBINS];
    logic [15:0]        shadow_range [NBINS];
    logic [15:0]        shadow_level [NBINS];
    bin_read_t          pending_reads [$];
    int                 hit_bins [$];

    int err_count;
    int n_add, n_read, n_clear, n_kept, n_checked;
    int burst_left;
    int hold_reqs, hold_seen, hold_left;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("tb: done, errors");
        $finish;
    end

    // Vectoring CORDIC angle, Q2.13 radians
    function automatic longint cordic_angle(longint x, longint y);
        longint cx, cy, z, nx, ny, sx, sy;
        longint atan_q16 [16] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                                  256, 128, 64, 32, 16, 8, 4, 2};
        z = 0;
        if (x == 0 && y == 0) return 0;
        cx = x * 65536;
        cy = y * 65536;
        if (cx < 0) begin
            if (cy >= 0) begin
                nx = cy; ny = -cx; z = 102944;
            end else begin
                nx = -cy; ny = cx; z = -102944;
            end
            cx = nx; cy = ny;
        end
        for (int i = 0; i < 16; i++) begin
            sx = cx >>> i;
            sy = cy >>> i;
            if (cy > 0) begin
                nx = cx + sy; ny = cy - sx; z += atan_q16[i];
            end else begin
                nx = cx - sy; ny = cy + sx; z -= atan_q16[i];
            end
            cx = nx; cy = ny;
        end
        z = (z + 4) >>> 3;
        if (z > 25736) z = 25736;
        if (z < -25736) z = -25736;
        return z;
    endfunction

    function automatic longint unsigned root_of(longint unsigned v);
        longint unsigned r, bitv;
        r = 0;
        bitv = 64'd1 << 34;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= r + bitv) begin
                v -= r + bitv;
                r = (r >> 1) + bitv;
            end else begin
                r >>= 1;
            end
            bitv >>= 2;
        end
        return r;
    endfunction

    // Bin a point lands in, or -1 when it is dropped
    function automatic int bin_of(logic signed [15:0] x, logic signed [15:0] y, logic ok);
        longint          ang;
        longint unsigned rsq, idx;
        if (!ok) return -1;
        rsq = longint'(x) * x + longint'(y) * y;
        if (rsq < longint'(near_limit) * near_limit) return -1;
        ang = cordic_angle(x, y);
        if (ang < win_min || ang > win_max) return -1;
        if (win_step == 0) return -1;
        idx = longint'(ang - win_min) / win_step;
        if (idx >= NBINS) return -1;
        return int'(idx);
    endfunction

    // Apply one accepted beat to the shadow and queue any read result
    function automatic void predict_beat(logic [1:0] act, logic signed [15:0] x,
                                         logic signed [15:0] y, logic [15:0] lvl,
                                         logic ok, logic [8:0] rb);
        int              b;
        longint unsigned r;
        bin_read_t       rd;
        case (act)
            ACT_CLEAR: begin
                foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;
                hit_bins.delete();
                n_clear++;
            end
            ACT_ADD: begin
                n_add++;
                b = bin_of(x, y, ok);
                if (b >= 0) begin
                    r = (root_of(4 * (longint'(x) * x + longint'(y) * y)) + 1) >> 1;
                    if (!shadow_valid[b] || r < shadow_range[b]) begin
                        shadow_valid[b] = 1'b1;
                        shadow_range[b] = r[15:0];
                        shadow_level[b] = lvl;
                        n_kept++;
                    end
                    hit_bins.insert(hit_bins.size(), b);
                    if (hit_bins.size() > 64) void'(hit_bins.pop_front());
                end
            end
            ACT_READ: begin
                n_read++;
                rd = '0;
                if (shadow_valid[rb]) begin
                    rd.range_mm = shadow_range[rb];
                    rd.level    = shadow_level[rb];
                    rd.filled   = 1'b1;
                end
                pending_reads.insert(pending_reads.size(), rd);
            end
            default: ;
        endcase
    endfunction

    // Send one beat; returns at the falling edge after it was accepted
    task automatic send_beat(logic [1:0] act, logic signed [15:0] x, logic signed [15:0] y,
                             logic [15:0] lvl, logic ok, logic [8:0] rb);
        if (burst_left == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 16);
        end
        burst_left--;
        s_action = act; s_x_mm = x; s_y_mm = y;
        s_point_intensity = lvl; s_point_ok = ok; s_read_bin = rb;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        predict_beat(act, x, y, lvl, ok, rb);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_valid = 1'b0;
        while (pending_reads.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_we = 1'b1; cfg_addr = idx; cfg_wdata = val;
        @(negedge aclk);
        cfg_we = 1'b0;
        case (idx)
            CFG_ANGLE_MIN:  win_min    = val;
            CFG_ANGLE_MAX:  win_max    = val;
            CFG_ANGLE_STEP: win_step   = val[13:0];
            default:        near_limit = val[14:0];
        endcase
    endtask

    task automatic set_window(int amin, int amax, int step, int rmin);
        wait_drained();
        write_reg(CFG_ANGLE_MIN, 16'(amin));
        write_reg(CFG_ANGLE_MAX, 16'(amax));
        write_reg(CFG_ANGLE_STEP, 16'(step));
        write_reg(CFG_RANGE_MIN, 16'(rmin));
    endtask

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom_range(0, 65535));
            1:       return 16'($signed($urandom_range(0, 4000)) - 2000);
            2:       return 16'($signed($urandom_range(0, 600)) - 300);
            default: return 16'($signed($urandom_range(0, 20000)) - 10000);
        endcase
    endfunction

    function automatic logic [8:0] pick_bin();
        if (hit_bins.size() != 0 && $urandom_range(0, 3) != 0)
            return 9'(hit_bins[$urandom_range(0, hit_bins.size() - 1)]);
        return 9'($urandom_range(0, NBINS - 1));
    endfunction

    // Add a point with a fresh random intensity
    task automatic add_point(logic signed [15:0] x, logic signed [15:0] y, logic ok);
        send_beat(ACT_ADD, x, y, 16'($urandom_range(0, 65535)), ok, 9'($urandom));
    endtask

    task automatic read_bin(logic [8:0] b);
        send_beat(ACT_READ, 16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom), b);
    endtask

    task automatic random_beats(int n, int clear_pct);
        int roll;
        for (int i = 0; i < n; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < clear_pct)
                send_beat(ACT_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom),
                          1'($urandom), 9'($urandom));
            else if (roll < 4)
                send_beat(ACT_NONE, 16'($urandom), 16'($urandom), 16'($urandom),
                          1'($urandom), 9'($urandom));
            else if (roll < 62)
                add_point(rand_coord(), rand_coord(), $urandom_range(0, 9) != 0);
            else
                read_bin(pick_bin());
        end
    endtask

    // Corners of the fields and each special case at reset settings, then the origin under a full window
    task automatic test_directed();
        int b;
        add_point(16'sd1000, 16'sd0, 1'b1);
        read_bin(9'(bin_of(16'sd1000, 16'sd0, 1'b1)));
        add_point(16'sd800, 16'sd0, 1'b1);
        send_beat(ACT_ADD, 16'sd800, 16'sd0, 16'hFFFF, 1'b1, 9'h1FF);
        read_bin(9'(bin_of(16'sd800, 16'sd0, 1'b1)));
        add_point(16'sd0, 16'sd900, 1'b0);
        read_bin(9'(bin_of(16'sd0, 16'sd900, 1'b1)));
        add_point(16'sd100, 16'sd100, 1'b1);
        read_bin(9'(bin_of(16'sd250, 16'sd250, 1'b1)));
        add_point(-16'sd32768, -16'sd32768, 1'b1);
        add_point(16'sd32767, 16'sd32767, 1'b1);
        add_point(-16'sd32768, 16'sd1, 1'b1);
        add_point(-16'sd5000, -16'sd1, 1'b1);
        add_point(-16'sd4000, 16'sd0, 1'b1);
        b = bin_of(-16'sd32768, -16'sd32768, 1'b1);
        read_bin(b < 0 ? 9'd0 : 9'(b));
        read_bin(9'd511);
        read_bin(9'd0);
        send_beat(ACT_NONE, 16'sd500, 16'sd0, 16'h1234, 1'b1, 9'd3);
        send_beat(ACT_CLEAR, '0, '0, '0, 1'b0, '0);
        read_bin(9'(bin_of(16'sd1000, 16'sd0, 1'b1)));
        set_window(-25736, 25736, 8192, 0);
        add_point(16'sd0, 16'sd0, 1'b1);
        read_bin(9'(bin_of(16'sd0, 16'sd0, 1'b1)));
        read_bin(9'd6);
    endtask

    // Window settings including extremes, zero step and an inverted window
    task automatic test_windows();
        set_window(-25736, 25736, 1, 0);
        random_beats(80, 0);
        set_window(25736, -25736, 115, 0);
        random_beats(40, 0);
        set_window(-25736, 25736, 0, 0);
        random_beats(40, 0);
        set_window(-8000, 8000, 40, 32767);
        random_beats(60, 0);
        set_window(-2000, 3000, 7, 120);
        random_beats(100, 1);
        set_window(-1, 0, 8192, 1);
        random_beats(40, 0);
        set_window(-25735, 25735, 115, 250);
    endtask

    // Stop the receiver for a long while and keep offering reads
    task automatic test_backpressure();
        hold_reqs++;
        for (int i = 0; i < 30; i++) read_bin(pick_bin());
    endtask

    task automatic test_random();
        for (int i = 0; i < 4; i++) begin
            set_window(-$urandom_range(0, 25736), $urandom_range(0, 25736),
                       $urandom_range(20, 400), $urandom_range(0, 1500));
            random_beats(220, 2);
        end
    endtask

    // Receiver stall pattern, plus long hold-offs on request
    initial begin
        int mode, phase;
        m_ready = 1'b0; hold_seen = 0; hold_left = 0; mode = 0; phase = 0;
        forever begin
            @(negedge aclk);
            if (hold_seen != hold_reqs) begin
                hold_seen = hold_reqs;
                hold_left = 400;
            end
            phase++;
            if (phase % 64 == 0) mode = $urandom_range(0, 2);
            if (hold_left > 0) begin
                hold_left--;
                m_ready = 1'b0;
            end else begin
                case (mode)
                    0:       m_ready = 1'b1;
                    1:       m_ready = 1'($urandom_range(0, 1));
                    default: m_ready = (phase % 5) < 3;
                endcase
            end
        end
    end

    // Compare each result beat with the oldest expected read
    always @(posedge aclk) begin
        bin_read_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_reads.size() == 0) begin
                $error("result beat with no read outstanding");
                err_count++;
            end else begin
                want = pending_reads.pop_front();
                n_checked++;
                if (m_range_mm !== want.range_mm) begin
                    $error("range_mm: expected %0d, got %0d", want.range_mm, m_range_mm);
                    err_count++;
                end
                if (m_bin_intensity !== want.level) begin
                    $error("bin_intensity: expected %0d, got %0d", want.level, m_bin_intensity);
                    err_count++;
                end
                if (m_bin_filled !== want.filled) begin
                    $error("bin_filled: expected %0d, got %0d", want.filled, m_bin_filled);
                    err_count++;
                end
            end
        end
    end

    initial begin
        int guard;
        err_count = 0; n_add = 0; n_read = 0; n_clear = 0; n_kept = 0; n_checked = 0;
        burst_left = 0; hold_reqs = 0;
        win_min = ANGLE_MIN_RST; win_max = ANGLE_MAX_RST;
        win_step = ANGLE_STEP_RST; near_limit = RANGE_MIN_RST;
        foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;
        aresetn = 1'b0; cfg_we = 1'b0; cfg_addr = '0; cfg_wdata = '0;
        s_valid = 1'b0; s_action = '0; s_x_mm = '0; s_y_mm = '0;
        s_point_intensity = '0; s_point_ok = 1'b0; s_read_bin = '0;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_backpressure();
        test_windows();
        test_backpressure();
        test_random();

        // Drain outstanding reads, then let the block settle
        s_valid = 1'b0;
        guard = 0;
        while (pending_reads.size() != 0 && guard < 100000) begin
            @(negedge aclk);
            guard++;
        end
        repeat (SETTLE) @(negedge aclk);
        if (pending_reads.size() != 0) begin
            $error("%0d reads never answered", pending_reads.size());
            err_count++;
        end
        $display("tb: %0d adds (%0d kept), %0d reads checked of %0d, %0d clears",
                 n_add, n_kept, n_checked, n_read, n_clear);
        $display("tb: window settings swept incl. zero step, inverted and full range");
        if (err_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
